[hdl/fbpa_pkg.sv]
// ---------------------------------------------------------------------------
// Fixed block pool allocator package
// Shared widths, operation and status codes, and the scan result type.
// ---------------------------------------------------------------------------
package fbpa_pkg;

  // Default pool capacity in blocks.
  localparam int unsigned CAPACITY_DEF = 64;

  // Fixed field widths.
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned IDX_W    = 6;
  localparam int unsigned CNT_W    = 7;
  localparam int unsigned STATUS_W = 2;

  // The scanner looks at one digit of the used map per cycle.
  localparam int unsigned DIGIT_W   = 8;
  localparam int unsigned DIGIT_LOG = 3;

  // Reset value of the initial block count register.
  localparam logic [CNT_W-1:0] INIT_RESET = 7'd64;

  // Operation codes carried by an item.
  typedef enum logic [KIND_W-1:0] {
    KIND_ALLOC   = 2'd0,
    KIND_FREE    = 2'd1,
    KIND_RELEASE = 2'd2,
    KIND_FORCE   = 2'd3
  } kind_e;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK          = 2'd0,
    STAT_NOT_FOUND   = 2'd1,
    STAT_OUTSTANDING = 2'd2,
    STAT_FULL        = 2'd3
  } status_e;

  // Outcome of one scan of the used map.
  typedef struct packed {
    logic             done;
    logic             found;
    logic [IDX_W-1:0] index;
  } scan_res_t;

endpackage

[hdl/fbpa_req_if.sv]
// ---------------------------------------------------------------------------
// Request channel
// Carries one allocator operation item with a valid/ready handshake.
// ---------------------------------------------------------------------------
interface fbpa_req_if;
  logic                          valid;
  logic                          ready;
  logic [fbpa_pkg::KIND_W-1:0]   kind;
  logic [fbpa_pkg::IDX_W-1:0]    block_index;

  modport source (output valid, output kind, output block_index, input ready);
  modport sink   (input valid, input kind, input block_index, output ready);
endinterface

[hdl/fbpa_rsp_if.sv]
// ---------------------------------------------------------------------------
// Response channel
// Carries one allocator result item with a valid/ready handshake.
// ---------------------------------------------------------------------------
interface fbpa_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [fbpa_pkg::STATUS_W-1:0] status;
  logic [fbpa_pkg::IDX_W-1:0]    granted_index;
  logic [fbpa_pkg::CNT_W-1:0]    total_count;
  logic [fbpa_pkg::CNT_W-1:0]    free_count;

  modport source (output valid, output status, output granted_index,
                  output total_count, output free_count, input ready);
  modport sink   (input valid, input status, input granted_index,
                  input total_count, input free_count, output ready);
endinterface

[hdl/fbpa_cfg_if.sv]
// ---------------------------------------------------------------------------
// Configuration write channel
// Carries the initial block count register write data.
// ---------------------------------------------------------------------------
interface fbpa_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [fbpa_pkg::CNT_W-1:0] initial_blocks;

  modport source (output valid, output initial_blocks, input ready);
  modport sink   (input valid, input initial_blocks, output ready);
endinterface

[hdl/fbpa_scan.sv]
// ---------------------------------------------------------------------------
// Digit-serial free block scanner
// Shifts a snapshot of the used map one digit per cycle and reports the
// lowest clear bit. Bits beyond the capacity read as used.
// ---------------------------------------------------------------------------
module fbpa_scan #(
  parameter int unsigned CAPACITY = fbpa_pkg::CAPACITY_DEF,
  localparam int unsigned NDIG    = (CAPACITY + fbpa_pkg::DIGIT_W - 1) / fbpa_pkg::DIGIT_W,
  localparam int unsigned MAP_W   = NDIG * fbpa_pkg::DIGIT_W
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [MAP_W-1:0]      map_i,
  output fbpa_pkg::scan_res_t   res_o
);
  import fbpa_pkg::*;

  localparam int unsigned DGW = (NDIG > 1) ? $clog2(NDIG) : 1;

  logic [MAP_W-1:0]     sh_q;
  logic [MAP_W-1:0]     pad;
  logic [DGW-1:0]       dig_q;
  logic                 busy_q;
  logic                 zero_any;
  logic [DIGIT_LOG-1:0] pos;
  logic                 last_dig;

  // Positions past the capacity are marked used so they are never granted.
  always_comb begin
    for (int i = 0; i < MAP_W; i++) begin
      pad[i] = (i >= CAPACITY);
    end
  end

  // Priority encode the lowest clear bit of the current digit.
  always_comb begin
    zero_any = 1'b0;
    pos      = '0;
    for (int b = DIGIT_W - 1; b >= 0; b--) begin
      if (!sh_q[b]) begin
        zero_any = 1'b1;
        pos      = DIGIT_LOG'(b);
      end
    end
  end

  assign last_dig = (dig_q == DGW'(NDIG - 1));

  // Scan control: one digit per cycle until a clear bit or the last digit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      dig_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      dig_q  <= '0;
    end else if (busy_q) begin
      if (zero_any || last_dig) begin
        busy_q <= 1'b0;
      end else begin
        dig_q <= dig_q + 1'b1;
      end
    end
  end

  // Map snapshot shift register.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sh_q <= map_i | pad;
    end else if (busy_q) begin
      sh_q <= sh_q >> DIGIT_W;
    end
  end

  assign res_o.done  = busy_q && (zero_any || last_dig);
  assign res_o.found = zero_any;
  assign res_o.index = (IDX_W'(dig_q) << DIGIT_LOG) | IDX_W'(pos);

endmodule

[hdl/fixed_block_pool_allocator.sv]
// ---------------------------------------------------------------------------
// Fixed block pool allocator
// Free and release items pass from accept straight to the done state; alloc
// items pass through the scan state first. The result is committed to the
// output register once it is empty or being drained. No new item is taken
// until that commit; the scanner tests 8 bits of the used map per cycle.
// Reset: pool holds min(64, CAPACITY) blocks, none in use, output empty.
// ---------------------------------------------------------------------------
module fixed_block_pool_allocator #(
  parameter int unsigned CAPACITY = fbpa_pkg::CAPACITY_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  fbpa_req_if.sink   req_i,
  fbpa_cfg_if.sink   cfg_i,
  fbpa_rsp_if.source rsp_o
);
  import fbpa_pkg::*;

  localparam int unsigned NDIG   = (CAPACITY + DIGIT_W - 1) / DIGIT_W;
  localparam int unsigned MAP_W  = NDIG * DIGIT_W;
  localparam int unsigned MAP_IW = $clog2(MAP_W);
  localparam logic [CNT_W-1:0] CAP_CNT    = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] POOL_RESET = (INIT_RESET > CAP_CNT) ? CAP_CNT : INIT_RESET;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [KIND_W-1:0] kind_q;
  logic [IDX_W-1:0] idx_q;
  logic             found_q;
  logic [IDX_W-1:0] zidx_q;

  logic [MAP_W-1:0] used_q, used_d;
  logic [CNT_W-1:0] pool_q, pool_d;
  logic [CNT_W-1:0] inuse_q, inuse_d;

  logic             out_valid_q;
  status_e          status_q, status_d;
  logic [IDX_W-1:0] grant_q, grant_d;
  logic [CNT_W-1:0] total_q;
  logic [CNT_W-1:0] free_q;

  logic             req_fire;
  logic             cfg_fire;
  logic             commit;
  logic             scan_start;
  scan_res_t        scan_res;

  // A pending register write goes ahead of a request item offered in the same cycle.
  assign req_i.ready = (state_q == S_IDLE) && !cfg_i.valid;
  assign cfg_i.ready = (state_q == S_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign cfg_fire    = cfg_i.valid && cfg_i.ready;
  assign scan_start  = req_fire && (req_i.kind == KIND_ALLOC);

  // A result is committed once the output register is free or being drained.
  assign commit = (state_q == S_DONE) && (!out_valid_q || rsp_o.ready);

  fbpa_scan #(
    .CAPACITY (CAPACITY)
  ) u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (scan_start),
    .map_i   (used_q),
    .res_o   (scan_res)
  );

  // Sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          state_d = scan_start ? S_SCAN : S_DONE;
        end
      end
      S_SCAN: begin
        if (scan_res.done) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (commit) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Pool update and result for the item being committed, or a register write.
  always_comb begin
    used_d   = used_q;
    pool_d   = pool_q;
    inuse_d  = inuse_q;
    status_d = STAT_OK;
    grant_d  = '0;
    if (cfg_fire) begin
      used_d  = '0;
      inuse_d = '0;
      pool_d  = (cfg_i.initial_blocks > CAP_CNT) ? CAP_CNT : cfg_i.initial_blocks;
    end else begin
      case (kind_q)
        KIND_ALLOC: begin
          // A clear bit at or past the pool end is the pool end itself.
          if (found_q) begin
            used_d[zidx_q[MAP_IW-1:0]] = 1'b1;
            inuse_d = inuse_q + 1'b1;
            grant_d = zidx_q;
            if ({1'b0, zidx_q} >= pool_q) begin
              pool_d = pool_q + 1'b1;
            end
          end else begin
            status_d = STAT_FULL;
          end
        end
        KIND_FREE: begin
          if (({1'b0, idx_q} < pool_q) && used_q[idx_q[MAP_IW-1:0]]) begin
            used_d[idx_q[MAP_IW-1:0]] = 1'b0;
            inuse_d = inuse_q - 1'b1;
          end else begin
            status_d = STAT_NOT_FOUND;
          end
        end
        KIND_RELEASE: begin
          if (inuse_q != '0) begin
            status_d = STAT_OUTSTANDING;
          end else begin
            used_d  = '0;
            inuse_d = '0;
            pool_d  = '0;
          end
        end
        default: begin
          used_d  = '0;
          inuse_d = '0;
          pool_d  = '0;
        end
      endcase
    end
  end

  // Control and pool state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      used_q      <= '0;
      pool_q      <= POOL_RESET;
      inuse_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (commit || cfg_fire) begin
        used_q  <= used_d;
        pool_q  <= pool_d;
        inuse_q <= inuse_d;
      end
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Item and scan payload registers.
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      kind_q <= req_i.kind;
      idx_q  <= req_i.block_index;
    end
    if ((state_q == S_SCAN) && scan_res.done) begin
      found_q <= scan_res.found;
      zidx_q  <= scan_res.index;
    end
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (commit) begin
      status_q <= status_d;
      grant_q  <= grant_d;
      total_q  <= pool_d;
      free_q   <= pool_d - inuse_d;
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.status        = status_q;
  assign rsp_o.granted_index = grant_q;
  assign rsp_o.total_count   = total_q;
  assign rsp_o.free_count    = free_q;

  // The in-use count never exceeds the pool size.
  assert property (@(posedge clk_i) disable iff (!rst_ni) inuse_q <= pool_q)
    else $error("in-use count exceeds pool size");

  // The pool never grows past its capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni) pool_q <= CAP_CNT)
    else $error("pool size exceeds capacity");

  // The scanner finishes only while the sequencer waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni) scan_res.done |-> state_q == S_SCAN)
    else $error("scan finished outside the scan state");

  // A new result is loaded only from the commit state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_DONE)
    else $error("result presented without a commit");

endmodule
